/* rtl/rotor3d_arithmetic_unit_defines.svh */
// ----------------------------------------------------------------------------
// rotor3d_arithmetic_unit_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ROTOR3D_ARITHMETIC_UNIT_DEFINES_SVH
`define ROTOR3D_ARITHMETIC_UNIT_DEFINES_SVH

// clocked assertion, off while reset is high
`define R3AU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define R3AU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/r3au_pkg.sv */
// ----------------------------------------------------------------------------
// r3au_pkg
// Operation and status codes and fixed pipeline constants of the rotor unit.
// ----------------------------------------------------------------------------
package r3au_pkg;

  // operation codes
  localparam logic [1:0] OP_ROTATE       = 2'd0;
  localparam logic [1:0] OP_COMPOSE      = 2'd1;
  localparam logic [1:0] OP_FROM_VECTORS = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_DEGENERATE  = 2'd1;
  localparam logic [1:0] ST_SATURATED   = 2'd2;

  // normalized magnitude width before the square root
  localparam int NORM_BITS = 30;
  // square root iterations, one result bit each
  localparam int SQRT_STEPS = 32;
  // unit vector stages besides the root bits and all quotient bits but one
  localparam int UNIT_FIXED_STAGES = 8;

endpackage

/* rtl/r3au_unit_vec.sv */
// ----------------------------------------------------------------------------
// r3au_unit_vec
// Pipelined unit vector: normalize, sum of squares, bit-serial square root
// stages and restoring division stages, one vector per cycle while en is high.
// ----------------------------------------------------------------------------
module r3au_unit_vec #(
  parameter int IW = 16,
  parameter int FB = 14
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2:0][IW-1:0]   c,
  output logic [2:0][FB+1:0]   u,
  output logic                 ok
);
  import r3au_pkg::*;

  localparam int QW = FB + 1;
  localparam int TW = NORM_BITS + 1;
  localparam int SQW = 2 * TW;
  localparam int RW = SQW + 1;
  localparam int DW = TW + FB + 1;
  localparam int LW = $clog2(IW + 1);
  localparam int XW = IW + NORM_BITS + 1;
  localparam int SQ = SQRT_STEPS;

  // stage a: magnitudes
  logic [2:0][IW-1:0] ta;
  logic [2:0]         neg_a;
  // stage b: bit length of the largest magnitude
  logic [2:0][IW-1:0] tb;
  logic [2:0]         neg_b;
  logic [LW-1:0]      len_b;
  logic               ok_b;
  logic [IW-1:0]      mx_c;
  logic [LW-1:0]      len_c;
  // stage c: normalized magnitudes
  logic [2:0][TW-1:0] tc;
  logic [2:0]         neg_c;
  logic               ok_c;
  logic [XW-1:0]      rnd_c;
  logic [2:0][XW-1:0] xs_c;
  // stage d: squares
  logic [2:0][SQW-1:0] sq_d;
  logic [2:0][TW-1:0]  td;
  logic [2:0]          neg_d;
  logic                ok_d;

  // square root pipeline, index 0 holds the sum of squares
  logic [RW-1:0]      rs_s [SQ+1];
  logic [RW-1:0]      rs_r [SQ+1];
  logic [2:0][TW-1:0] tq   [SQ+1];
  logic [2:0]         nq   [SQ+1];
  logic               okq  [SQ+1];
  logic [RW-1:0]      sbit  [SQ];
  logic [RW-1:0]      trial [SQ];
  logic               take  [SQ];

  // division pipeline, index 0 holds the rounded numerators
  logic [2:0][DW-1:0] dr  [QW+1];
  logic [2:0][QW-1:0] dq  [QW+1];
  logic [TW-1:0]      dd  [QW+1];
  logic [2:0]         dn  [QW+1];
  logic               dok [QW+1];
  logic [2:0][DW-1:0] dsh [QW];
  logic [TW-1:0]      root;

  // largest magnitude and its bit length
  always_comb begin
    mx_c = ta[0];
    if (ta[1] > mx_c) mx_c = ta[1];
    if (ta[2] > mx_c) mx_c = ta[2];
    len_c = '0;
    for (int k = 0; k < IW; k++) begin
      if (mx_c[k]) len_c = LW'(k + 1);
    end
  end

  // scale so the largest magnitude has NORM_BITS bits, rounding half up
  always_comb begin
    rnd_c = (len_b != '0) ? (XW'(1) << (len_b - LW'(1))) : '0;
    for (int i = 0; i < 3; i++) begin
      xs_c[i] = ((XW'(tb[i]) << NORM_BITS) + rnd_c) >> len_b;
    end
  end

  // square root trial values
  always_comb begin
    for (int k = 0; k < SQ; k++) begin
      sbit[k]  = RW'(1) << (2 * (SQ - 1 - k));
      trial[k] = rs_r[k] + sbit[k];
      take[k]  = rs_s[k] >= trial[k];
    end
  end

  assign root = rs_r[SQ][TW-1:0];

  // shifted divisors
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < 3; i++) begin
        dsh[j][i] = DW'(dd[j]) << (QW - 1 - j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes
      for (int i = 0; i < 3; i++) begin
        neg_a[i] <= c[i][IW-1];
        ta[i]    <= c[i][IW-1] ? (IW'(0) - c[i]) : c[i];
      end
      // bit length
      tb    <= ta;
      neg_b <= neg_a;
      len_b <= len_c;
      ok_b  <= mx_c != '0;
      // normalize
      for (int i = 0; i < 3; i++) begin
        tc[i] <= xs_c[i][TW-1:0];
      end
      neg_c <= neg_b;
      ok_c  <= ok_b;
      // squares
      for (int i = 0; i < 3; i++) begin
        sq_d[i] <= SQW'(tc[i]) * SQW'(tc[i]);
      end
      td    <= tc;
      neg_d <= neg_c;
      ok_d  <= ok_c;
      // sum of squares
      rs_s[0] <= RW'(sq_d[0]) + RW'(sq_d[1]) + RW'(sq_d[2]);
      rs_r[0] <= '0;
      tq[0]   <= td;
      nq[0]   <= neg_d;
      okq[0]  <= ok_d;
      // square root steps
      for (int k = 0; k < SQ; k++) begin
        rs_s[k+1] <= take[k] ? (rs_s[k] - trial[k]) : rs_s[k];
        rs_r[k+1] <= take[k] ? ((rs_r[k] >> 1) + sbit[k]) : (rs_r[k] >> 1);
        tq[k+1]   <= tq[k];
        nq[k+1]   <= nq[k];
        okq[k+1]  <= okq[k];
      end
      // numerators with half the divisor for rounding
      for (int i = 0; i < 3; i++) begin
        dr[0][i] <= (DW'(tq[SQ][i]) << FB) + DW'(root >> 1);
      end
      dq[0]  <= '0;
      dd[0]  <= root;
      dn[0]  <= nq[SQ];
      dok[0] <= okq[SQ];
      // quotient bits, most significant first
      for (int j = 0; j < QW; j++) begin
        for (int i = 0; i < 3; i++) begin
          if (dr[j][i] >= dsh[j][i]) begin
            dr[j+1][i] <= dr[j][i] - dsh[j][i];
            dq[j+1][i] <= dq[j][i] | (QW'(1) << (QW - 1 - j));
          end else begin
            dr[j+1][i] <= dr[j][i];
            dq[j+1][i] <= dq[j][i];
          end
        end
        dd[j+1]  <= dd[j];
        dn[j+1]  <= dn[j];
        dok[j+1] <= dok[j];
      end
      // apply signs
      for (int i = 0; i < 3; i++) begin
        u[i] <= dn[QW][i] ? ((FB + 2)'(0) - (FB + 2)'(dq[QW][i]))
                          : (FB + 2)'(dq[QW][i]);
      end
      ok <= dok[QW];
    end
  end

endmodule

/* rtl/rotor3d_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rotor3d_arithmetic_unit
// Rotor unit: rotate a vector, compose two rotors, or build the rotor that
// turns one vector toward another, selected per word.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                      | tuser
//  s_*     | in  | left_c0..c3, right_c0..c3               | operation
//  m_*     | out | result_c0..c3                           | status
//
//  one word per cycle in and out while m_* is not stalled; every word passes
//  through the whole pipeline, which holds two unit vector passes in series,
//  each of 32 square root stages plus FRACTION_BITS+1 quotient stages. rst
//  clears all valid bits. a stall at m_* freezes the whole pipeline; words in
//  flight hold their place and s_tready drops.
// ----------------------------------------------------------------------------
module rotor3d_arithmetic_unit #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // left_c0, left_c1, left_c2, left_c3, right_c0, right_c1, right_c2, right_c3
  input  logic [8*COMPONENT_WIDTH-1:0]   s_tdata,
  // operation
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // result_c0, result_c1, result_c2, result_c3
  output logic [4*COMPONENT_WIDTH-1:0]   m_tdata,
  // status
  output logic [1:0]                     m_tuser
);
  import r3au_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int UL = SQRT_STEPS + FB + UNIT_FIXED_STAGES;
  localparam int F  = 2 * UL + 2;
  localparam int PW = 2 * CW;
  localparam int SW = (2 * CW + 3 - FB > 2) ? 2 * CW + 3 - FB : 2;
  localparam int QPW = SW + CW;
  localparam int HW = FB + 2;
  localparam int HPW = 2 * HW;
  localparam int FW0 = (3 * CW + 5 - FB > 2 * CW + 3) ? 3 * CW + 5 - FB : 2 * CW + 3;
  localparam int FW = ((FW0 > 2 * FB + 6) ? FW0 : 2 * FB + 6) + 1;
  localparam int FL = 2 * UL - 2;

  localparam logic signed [FW-1:0] MAXC = (FW'(1) <<< (CW - 1)) - FW'(1);
  localparam logic signed [FW-1:0] MINC = -(FW'(1) <<< (CW - 1));
  localparam logic [CW-1:0] MAX_CW = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] MIN_CW = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [CW-1:0] ONE_C  = (FB < CW - 1) ? CW'(64'd1 << FB) : MAX_CW;

  typedef struct packed {
    logic                 is_op2;
    logic [1:0]           st;
    logic [3:0][CW-1:0]   res;
  } fast_t;

  // rescale by 2^FB, rounding half up
  function automatic logic signed [FW-1:0] rnd_shift(input logic signed [FW-1:0] x);
    rnd_shift = (x + (FW'(1) <<< (FB - 1))) >>> FB;
  endfunction

  // rescale and clamp to the component range, saturation flag on top
  function automatic logic [CW:0] finish(input logic signed [FW-1:0] x);
    logic signed [FW-1:0] y;
    y = rnd_shift(x);
    if (y > MAXC) begin
      finish = {1'b1, MAX_CW};
    end else if (y < MINC) begin
      finish = {1'b1, MIN_CW};
    end else begin
      finish = {1'b0, y[CW-1:0]};
    end
  endfunction

  logic adv;
  logic v [F+1];

  // stage 0: input word
  logic [1:0]             op_s0;
  logic signed [CW-1:0]   l_s0 [4];
  logic signed [CW-1:0]   r_s0 [4];
  // stage 1: all left by right products
  logic [1:0]             op_s1;
  logic signed [CW-1:0]   l_s1 [4];
  logic signed [PW-1:0]   pr [4][4];
  // stage 2: rotate half products, compose result
  logic [1:0]             op_s2;
  logic signed [CW-1:0]   l_s2 [4];
  logic signed [SW-1:0]   sv [4];
  logic [3:0][CW-1:0]     c1_s2;
  logic                   sat1_s2;
  logic signed [FW-1:0]   sv_sum [4];
  logic signed [FW-1:0]   sv_rs [4];
  logic signed [FW-1:0]   c1_sum [4];
  logic [CW:0]            c1_fin [4];
  // stage 3: rotate second products
  logic [1:0]             op_s3;
  logic signed [QPW-1:0]  qp [4][4];
  logic [3:0][CW-1:0]     c1_s3;
  logic                   sat1_s3;
  logic signed [FW-1:0]   r0_sum [3];
  logic [CW:0]            r0_fin [3];
  fast_t                  fast_c;
  fast_t                  fast_q [FL];

  // from-vectors path
  logic [2:0][HW-1:0]     na_u, nb_u, h_u;
  logic [2:0][HW:0]       hs;
  logic                   ok_a, ok_b, ok_h;
  logic [2:0][HW-1:0]     na_d [UL];
  logic                   okab_d [UL];
  logic signed [HPW-1:0]  hp [3][3];
  logic                   ok_all;
  logic signed [FW-1:0]   o_sum [4];
  logic [CW:0]            o_fin [4];

  // output register
  logic [3:0][CW-1:0]     res_c, res_o;
  logic [1:0]             st_c, st_o;

  // whole pipeline moves unless the output word is held
  assign adv      = !v[F] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = v[F];
  assign m_tdata  = res_o;
  assign m_tuser  = st_o;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= F; k++) v[k] <= 1'b0;
    end else if (adv) begin
      v[0] <= s_tvalid;
      for (int k = 1; k <= F; k++) v[k] <= v[k-1];
    end
  end

  // rotate half products and compose sums
  always_comb begin
    sv_sum[0] = FW'(pr[0][0]) + FW'(pr[1][1]) - FW'(pr[3][2]);
    sv_sum[1] = FW'(pr[0][1]) - FW'(pr[1][0]) + FW'(pr[2][2]);
    sv_sum[2] = FW'(pr[0][2]) - FW'(pr[2][1]) + FW'(pr[3][0]);
    sv_sum[3] = FW'(pr[1][2]) + FW'(pr[2][0]) + FW'(pr[3][1]);
    c1_sum[0] = FW'(pr[0][0]) - FW'(pr[1][1]) - FW'(pr[2][2]) - FW'(pr[3][3]);
    c1_sum[1] = FW'(pr[0][1]) + FW'(pr[1][0]) - FW'(pr[2][3]) + FW'(pr[3][2]);
    c1_sum[2] = FW'(pr[0][2]) + FW'(pr[1][3]) + FW'(pr[2][0]) - FW'(pr[3][1]);
    c1_sum[3] = FW'(pr[0][3]) - FW'(pr[1][2]) + FW'(pr[2][1]) + FW'(pr[3][0]);
    for (int i = 0; i < 4; i++) begin
      sv_rs[i]  = rnd_shift(sv_sum[i]);
      c1_fin[i] = finish(c1_sum[i]);
    end
  end

  // rotate output sums
  always_comb begin
    r0_sum[0] = FW'(qp[0][0]) + FW'(qp[1][1]) + FW'(qp[3][2]) - FW'(qp[2][3]);
    r0_sum[1] = FW'(qp[1][0]) - FW'(qp[0][1]) + FW'(qp[2][2]) + FW'(qp[3][3]);
    r0_sum[2] = FW'(qp[2][0]) + FW'(qp[3][1]) - FW'(qp[1][2]) + FW'(qp[0][3]);
    for (int i = 0; i < 3; i++) r0_fin[i] = finish(r0_sum[i]);
  end

  // early result for rotate, compose and the unused code, a mark for from-vectors
  always_comb begin
    fast_c = '0;
    case (op_s3)
      OP_ROTATE: begin
        for (int i = 0; i < 3; i++) fast_c.res[i] = r0_fin[i][CW-1:0];
        fast_c.st = (r0_fin[0][CW] || r0_fin[1][CW] || r0_fin[2][CW])
                    ? ST_SATURATED : ST_OK;
      end
      OP_COMPOSE: begin
        fast_c.res = c1_s3;
        fast_c.st  = sat1_s3 ? ST_SATURATED : ST_OK;
      end
      OP_FROM_VECTORS: begin
        fast_c.is_op2 = 1'b1;
      end
      default: begin
        fast_c.st = ST_OK;
      end
    endcase
  end

  // halfway vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hs[i] = (HW + 1)'($signed(na_u[i])) + (HW + 1)'($signed(nb_u[i]));
    end
  end

  r3au_unit_vec #(.IW(CW), .FB(FB)) u_vec_a (
    .clk (clk),
    .en  (adv),
    .c   ({l_s0[2], l_s0[1], l_s0[0]}),
    .u   (na_u),
    .ok  (ok_a)
  );

  r3au_unit_vec #(.IW(CW), .FB(FB)) u_vec_b (
    .clk (clk),
    .en  (adv),
    .c   ({r_s0[2], r_s0[1], r_s0[0]}),
    .u   (nb_u),
    .ok  (ok_b)
  );

  r3au_unit_vec #(.IW(HW + 1), .FB(FB)) u_vec_h (
    .clk (clk),
    .en  (adv),
    .c   (hs),
    .u   (h_u),
    .ok  (ok_h)
  );

  // dot and wedge sums, final select
  always_comb begin
    o_sum[0] = FW'(hp[0][0]) + FW'(hp[1][1]) + FW'(hp[2][2]);
    o_sum[1] = FW'(hp[0][1]) - FW'(hp[1][0]);
    o_sum[2] = FW'(hp[1][2]) - FW'(hp[2][1]);
    o_sum[3] = FW'(hp[2][0]) - FW'(hp[0][2]);
    for (int i = 0; i < 4; i++) o_fin[i] = finish(o_sum[i]);
    res_c = fast_q[FL-1].res;
    st_c  = fast_q[FL-1].st;
    if (fast_q[FL-1].is_op2) begin
      if (!ok_all) begin
        res_c = '0;
        res_c[0] = ONE_C;
        st_c = ST_DEGENERATE;
      end else begin
        for (int i = 0; i < 4; i++) res_c[i] = o_fin[i][CW-1:0];
        st_c = (o_fin[0][CW] || o_fin[1][CW] || o_fin[2][CW] || o_fin[3][CW])
               ? ST_SATURATED : ST_OK;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 0
      op_s0 <= s_tuser;
      for (int i = 0; i < 4; i++) begin
        l_s0[i] <= s_tdata[i*CW +: CW];
        r_s0[i] <= s_tdata[(i+4)*CW +: CW];
      end
      // stage 1
      op_s1 <= op_s0;
      for (int i = 0; i < 4; i++) begin
        l_s1[i] <= l_s0[i];
        for (int j = 0; j < 4; j++) pr[i][j] <= PW'(l_s0[i]) * PW'(r_s0[j]);
      end
      // stage 2
      op_s2 <= op_s1;
      for (int i = 0; i < 4; i++) begin
        l_s2[i]  <= l_s1[i];
        sv[i]    <= sv_rs[i][SW-1:0];
        c1_s2[i] <= c1_fin[i][CW-1:0];
      end
      sat1_s2 <= c1_fin[0][CW] || c1_fin[1][CW] || c1_fin[2][CW] || c1_fin[3][CW];
      // stage 3
      op_s3   <= op_s2;
      c1_s3   <= c1_s2;
      sat1_s3 <= sat1_s2;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) qp[i][j] <= QPW'(sv[i]) * QPW'(l_s2[j]);
      end
      // early results wait for the from-vectors path
      fast_q[0] <= fast_c;
      for (int k = 1; k < FL; k++) fast_q[k] <= fast_q[k-1];
      // first unit vector waits for the halfway unit vector
      na_d[0]   <= na_u;
      okab_d[0] <= ok_a && ok_b;
      for (int k = 1; k < UL; k++) begin
        na_d[k]   <= na_d[k-1];
        okab_d[k] <= okab_d[k-1];
      end
      // halfway by first unit vector products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          hp[i][j] <= HPW'($signed(h_u[i])) * HPW'($signed(na_d[UL-1][j]));
        end
      end
      ok_all <= okab_d[UL-1] && ok_h;
      // output word
      res_o <= res_c;
      st_o  <= st_c;
    end
  end

endmodule

/* rtl/r3au_checker.sv */
// ----------------------------------------------------------------------------
// r3au_checker
// Port level checks of the rotor unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotor3d_arithmetic_unit_defines.svh"

module r3au_checker #(
  parameter int COMPONENT_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [8*COMPONENT_WIDTH-1:0]   s_tdata,
  input logic [1:0]                     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [4*COMPONENT_WIDTH-1:0]   m_tdata,
  input logic [1:0]                     m_tuser
);
  import r3au_pkg::*;

  // a held output word keeps its contents
  `R3AU_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

  // a stalled output blocks the input side
  `R3AU_ASSERT_ALWAYS(a_backpressure, m_tvalid && !m_tready |-> !s_tready, "input accepted during output stall")

  // degenerate vectors give only the scalar part
  `R3AU_ASSERT(a_degen, m_tvalid && m_tuser == ST_DEGENERATE |-> m_tdata[4*COMPONENT_WIDTH-1:COMPONENT_WIDTH] == '0, "degenerate result has nonzero bivector part")

  // status is one of the three defined codes
  `R3AU_ASSERT(a_status, m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_DEGENERATE || m_tuser == ST_SATURATED, "undefined status code")

  // reset empties the pipeline
  `R3AU_ASSERT_ALWAYS(a_reset, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind rotor3d_arithmetic_unit r3au_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_r3au_checker (.*);

/* verif/rotor3d_arithmetic_unit_tb.sv */
// ----------------------------------------------------------------------------
// rotor3d_arithmetic_unit_tb
// Self-checking bench for the rotor unit. A behavioral predictor computes the
// expected result of every accepted word. Results are compared field by field
// in order, under random source and sink idling, a long sink stall and drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotor3d_arithmetic_unit_tb;
  import r3au_pkg::*;

  localparam int CW = 16;
  localparam int FB = 14;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  typedef struct packed {
    logic [CW-1:0] c3, c2, c1, c0;
    logic [1:0]    st;
  } rotor_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [8*CW-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [4*CW-1:0] m_tdata;
  logic [1:0] m_tuser;

  rotor_result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;

  always #1 clk = ~clk;

  rotor3d_arithmetic_unit #(.COMPONENT_WIDTH(CW), .FRACTION_BITS(FB)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // ---------------------------------------------------------------- predictor
  function automatic longint round_q(longint v);
    return (v + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic logic [CW-1:0] fit_component(longint v, inout bit sat);
    longint r;
    r = round_q(v);
    if (r > CMAX) begin
      sat = 1'b1;
      r = CMAX;
    end else if (r < CMIN) begin
      sat = 1'b1;
      r = CMIN;
    end
    return r[CW-1:0];
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // unit vector in fixed point, zero when the vector has no length
  function automatic bit unit_vector(input longint c[3], output longint u[3]);
    longint unsigned t[3], mx, sum, vlen, q;
    bit neg[3];
    int blen, s;
    mx = 0;
    sum = 0;
    blen = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      t[i] = neg[i] ? -c[i] : c[i];
      if (t[i] > mx) mx = t[i];
      u[i] = 0;
    end
    if (mx == 0) return 1'b0;
    while (blen < 64 && (mx >> blen) != 0) blen++;
    for (int i = 0; i < 3; i++) begin
      if (blen <= NORM_BITS) begin
        t[i] = t[i] << (NORM_BITS - blen);
      end else begin
        s = blen - NORM_BITS;
        t[i] = (t[i] + (64'd1 << (s - 1))) >> s;
      end
      sum += t[i] * t[i];
    end
    vlen = floor_sqrt(sum);
    if (vlen == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = ((t[i] << FB) + vlen / 2) / vlen;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic rotor_result_t predict_rotor(logic [1:0] op, logic [8*CW-1:0] data);
    longint l[4], r[4], sx, sy, sz, sxyz;
    longint va[3], vb[3], na[3], nb[3], hs[3], h[3];
    bit sat, ok;
    rotor_result_t res;
    sat = 1'b0;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      l[i] = longint'($signed(data[i*CW +: CW]));
      r[i] = longint'($signed(data[(i+4)*CW +: CW]));
    end
    case (op)
      OP_ROTATE: begin
        sx   = round_q(l[0]*r[0] + l[1]*r[1] - l[3]*r[2]);
        sy   = round_q(l[0]*r[1] - l[1]*r[0] + l[2]*r[2]);
        sz   = round_q(l[0]*r[2] - l[2]*r[1] + l[3]*r[0]);
        sxyz = round_q(l[1]*r[2] + l[2]*r[0] + l[3]*r[1]);
        res.c0 = fit_component(sx*l[0] + sy*l[1] + sxyz*l[2] - sz*l[3], sat);
        res.c1 = fit_component(sy*l[0] - sx*l[1] + sz*l[2] + sxyz*l[3], sat);
        res.c2 = fit_component(sz*l[0] + sxyz*l[1] - sy*l[2] + sx*l[3], sat);
      end
      OP_COMPOSE: begin
        res.c0 = fit_component(l[0]*r[0] - l[1]*r[1] - l[2]*r[2] - l[3]*r[3], sat);
        res.c1 = fit_component(l[0]*r[1] + l[1]*r[0] - l[2]*r[3] + l[3]*r[2], sat);
        res.c2 = fit_component(l[0]*r[2] + l[1]*r[3] + l[2]*r[0] - l[3]*r[1], sat);
        res.c3 = fit_component(l[0]*r[3] - l[1]*r[2] + l[2]*r[1] + l[3]*r[0], sat);
      end
      OP_FROM_VECTORS: begin
        for (int i = 0; i < 3; i++) begin
          va[i] = l[i];
          vb[i] = r[i];
        end
        ok = unit_vector(va, na);
        if (ok) ok = unit_vector(vb, nb);
        if (ok) begin
          for (int i = 0; i < 3; i++) hs[i] = na[i] + nb[i];
          ok = unit_vector(hs, h);
        end
        if (!ok) begin
          // degenerate input gives the identity rotor
          res.c0 = ((64'sd1 <<< FB) > CMAX) ? CMAX[CW-1:0] : CW'(64'sd1 <<< FB);
          res.st = ST_DEGENERATE;
        end else begin
          res.c0 = fit_component(h[0]*na[0] + h[1]*na[1] + h[2]*na[2], sat);
          res.c1 = fit_component(h[0]*na[1] - h[1]*na[0], sat);
          res.c2 = fit_component(h[1]*na[2] - h[2]*na[1], sat);
          res.c3 = fit_component(h[2]*na[0] - h[0]*na[2], sat);
        end
      end
      default: ;
    endcase
    if (res.st == ST_OK && sat) res.st = ST_SATURATED;
    return res;
  endfunction

  // ---------------------------------------------------------------- scoreboard
  // record every accepted input word and check every accepted output word
  always @(posedge clk) begin
    rotor_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pending_results.push_back(predict_rotor(s_tuser, s_tdata));
        op_count[s_tuser]++;
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word %h status %0d", m_tdata, m_tuser);
          errors++;
        end else begin
          want = pending_results.pop_front();
          words_checked++;
          if (m_tdata[0*CW +: CW] !== want.c0) begin
            $error("result_c0 expected %h actual %h", want.c0, m_tdata[0*CW +: CW]);
            errors++;
          end
          if (m_tdata[1*CW +: CW] !== want.c1) begin
            $error("result_c1 expected %h actual %h", want.c1, m_tdata[1*CW +: CW]);
            errors++;
          end
          if (m_tdata[2*CW +: CW] !== want.c2) begin
            $error("result_c2 expected %h actual %h", want.c2, m_tdata[2*CW +: CW]);
            errors++;
          end
          if (m_tdata[3*CW +: CW] !== want.c3) begin
            $error("result_c3 expected %h actual %h", want.c3, m_tdata[3*CW +: CW]);
            errors++;
          end
          if (m_tuser !== want.st) begin
            $error("status expected %0d actual %0d", want.st, m_tuser);
            errors++;
          end
        end
      end
    end
  end

  // sink ready, with random idling and an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      m_tready <= 1'b0;
      recv_hold = recv_hold - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_word(logic [1:0] op, logic [8*CW-1:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic send_parts(logic [1:0] op, logic [CW-1:0] l0, l1, l2, l3,
                            logic [CW-1:0] r0, r1, r2, r3);
    send_word(op, {r3, r2, r1, r0, l3, l2, l1, l0});
  endtask

  function automatic logic [CW-1:0] rand_component();
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(200)) - 100);
      2: return $urandom_range(1) ? CMAX[CW-1:0] : CMIN[CW-1:0];
      default: return CW'($signed($urandom_range(32767)) - 16384);
    endcase
  endfunction

  task automatic send_random_word();
    logic [CW-1:0] c[8];
    logic [1:0] op;
    op = ($urandom_range(19) == 0) ? OP_UNUSED : 2'($urandom_range(2));
    for (int i = 0; i < 8; i++) c[i] = rand_component();
    if (op == OP_FROM_VECTORS) begin
      case ($urandom_range(9))
        0: for (int i = 0; i < 3; i++) c[4+i] = -c[i];           // opposite
        1: for (int i = 0; i < 3; i++) c[4+i] = c[i];            // parallel
        2: for (int i = 0; i < 3; i++) c[i] = '0;                // zero vector
        default: ;
      endcase
    end
    send_parts(op, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    logic [CW-1:0] one, mx, mn;
    one = CW'(64'sd1 <<< FB);
    mx = CMAX[CW-1:0];
    mn = CMIN[CW-1:0];
    // rotate: identity, extremes, saturation
    send_parts(OP_ROTATE, one, '0, '0, '0, mx, mn, 16'd1, mx);
    send_parts(OP_ROTATE, '0, one, '0, '0, 16'd100, 16'd200, 16'd300, '0);
    send_parts(OP_ROTATE, mx, mx, mx, mx, mx, mx, mx, mx);
    send_parts(OP_ROTATE, mn, mn, mn, mn, mn, mn, mn, mn);
    send_parts(OP_ROTATE, 16'd11585, 16'd11585, '0, '0, mx, '0, mn, '0);
    // compose: identity, extremes
    send_parts(OP_COMPOSE, one, '0, '0, '0, 16'd1234, mn, mx, 16'd7);
    send_parts(OP_COMPOSE, mx, mx, mx, mx, mx, mx, mx, mx);
    send_parts(OP_COMPOSE, mn, mn, mn, mn, mn, mn, mn, mn);
    send_parts(OP_COMPOSE, mn, mx, mn, mx, mx, mn, mx, mn);
    // from vectors: zero, opposite, parallel, perpendicular, extremes
    send_parts(OP_FROM_VECTORS, '0, '0, '0, mx, 16'd1, 16'd2, 16'd3, '0);
    send_parts(OP_FROM_VECTORS, 16'd5, '0, '0, '0, '0, '0, '0, mx);
    send_parts(OP_FROM_VECTORS, 16'd1, '0, '0, '0, -16'sd1, '0, '0, '0);
    send_parts(OP_FROM_VECTORS, mx, mn, mx, '0, -mx, mx, -mx, '0);
    send_parts(OP_FROM_VECTORS, 16'd3, 16'd4, 16'd5, '0, 16'd3, 16'd4, 16'd5, '0);
    send_parts(OP_FROM_VECTORS, 16'd1, '0, '0, '0, '0, 16'd1, '0, '0);
    send_parts(OP_FROM_VECTORS, mn, mn, mn, mn, mx, mx, mx, mx);
    send_parts(OP_FROM_VECTORS, mx, '0, 16'd1, '0, '0, mn, '0, '0);
    // unused operation code
    send_parts(OP_UNUSED, mx, mn, mx, mn, mx, mn, mx, mn);
    send_parts(OP_UNUSED, '0, '0, '0, '0, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_mix(int n, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) send_random_word();
  endtask

  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 400;
    repeat (200) send_random_word();
    wait_drained();
  endtask

  initial begin : timeout_guard
    #1600000;
    $display("rotor3d_arithmetic_unit test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_corners();
    test_random_mix(200, 22, 59);
    test_random_mix(200, 59, 22);
    wait_drained();
    test_random_mix(200, 0, 0);
    test_backpressure_fill();
    test_random_mix(50, 10, 10);
    wait_drained();
    repeat (250) @(posedge clk);
    $display("sent %0d words (rotate %0d, compose %0d, from-vectors %0d, unused %0d)",
             words_sent, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("checked %0d results under idling, a long sink stall and drains",
             words_checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("rotor3d_arithmetic_unit test passed");
    end else begin
      $display("rotor3d_arithmetic_unit test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/r3au_pkg.sv
rtl/r3au_unit_vec.sv
rtl/rotor3d_arithmetic_unit.sv
rtl/r3au_checker.sv
verif/rotor3d_arithmetic_unit_tb.sv
